// ----- sv/ovl_pkg.sv -----
// shared types and constants for the ordered value list
package ovl_pkg;

  localparam int DATA_W       = 32;
  localparam int COUNT_W      = 5;
  localparam int CAPACITY_DEF = 16;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_DELETE = 2'd1,
    OP_SEARCH = 2'd2
  } ovl_op_e;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } ovl_status_e;

  // token that walks down the chain of cells
  typedef struct packed {
    logic vld;
    logic found;
  } ovl_tok_t;

endpackage

// ----- sv/ovl_cell.sv -----
// one cell of the list: holds one entry and passes the operation token on
module ovl_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 5
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ovl_pkg::ovl_tok_t                   tok_i,
  input  ovl_pkg::ovl_op_e                    op_i,
  input  logic signed [ovl_pkg::DATA_W-1:0]   value_i,
  input  logic [CNT_W-1:0]                    count_i,
  input  logic signed [ovl_pkg::DATA_W-1:0]   next_entry_i,
  output ovl_pkg::ovl_tok_t                   tok_o,
  output logic signed [ovl_pkg::DATA_W-1:0]   entry_o
);
  import ovl_pkg::*;

  localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

  logic signed [DATA_W-1:0] entry_q, entry_d;
  ovl_tok_t                 tok_q, tok_d;
  logic                     held;
  logic                     match;

  assign held  = IDX_C < count_i;
  assign match = held && (entry_q == value_i);

  always_comb begin
    entry_d   = entry_q;
    tok_d.vld = tok_i.vld;
    tok_d.found = tok_i.found;
    if (tok_i.vld) begin
      unique case (op_i)
        OP_APPEND: begin
          if (IDX_C == count_i) begin
            entry_d = value_i;
          end
        end
        OP_DELETE: begin
          // everything from the first match onward moves down one cell
          if (tok_i.found || match) begin
            entry_d = next_entry_i;
          end
          tok_d.found = tok_i.found || match;
        end
        OP_SEARCH: begin
          tok_d.found = tok_i.found || match;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o   = tok_q;
  assign entry_o = entry_q;

endmodule

// ----- sv/ordered_value_list_core.sv -----
// ordered value list: bounded list of signed values kept in a chain of cells
//
// one command channel: an item (operation_i, value_i) is taken at a rising
// edge with start_i high and busy_o low. operations: append at the tail,
// delete the earliest equal entry (later entries keep their order), search.
// each item gives one result on status_o and count_o, shown for exactly one
// cycle with done_o high; the receiver cannot stall, so it must take it then.
// the item token is registered in tok_q, walks through the CAPACITY cells,
// registered in each, and the result is registered with done_o; busy_o is
// high until then. a new item is not taken while one is in the chain; busy_o
// drops in the cycle of done_o, so the next item may be taken right there.
// an append to a full list leaves it unchanged and reports full.
// reset empties the list (count zero); entry contents are not cleared.
// count_o holds the entry count after the last operation.
module ordered_value_list_core #(
  parameter int CAPACITY = ovl_pkg::CAPACITY_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [1:0]                        operation_i,
  input  logic signed [ovl_pkg::DATA_W-1:0] value_i,
  output logic                              done_o,
  output logic [1:0]                        status_o,
  output logic [ovl_pkg::COUNT_W-1:0]       count_o
);
  import ovl_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int EXT_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

  logic                     busy_q, busy_d;
  logic                     done_q, done_d;
  ovl_tok_t                 tok_q;
  ovl_op_e                  op_q;
  logic signed [DATA_W-1:0] value_q;
  logic [CNT_W-1:0]         count_q, count_d;
  ovl_status_e              status_q, status_d;
  logic                     accept;

  ovl_tok_t                 tok_w   [CAPACITY+1];
  logic signed [DATA_W-1:0] entry_w [CAPACITY+1];
  logic [EXT_W-1:0]         count_ext;

  assign accept = start_i && !busy_q;

  assign tok_w[0]          = tok_q;
  assign entry_w[CAPACITY] = '0;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    ovl_cell #(
      .IDX   (g),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .tok_i        (tok_w[g]),
      .op_i         (op_q),
      .value_i      (value_q),
      .count_i      (count_q),
      .next_entry_i (entry_w[g+1]),
      .tok_o        (tok_w[g+1]),
      .entry_o      (entry_w[g])
    );
  end

  // result once the token leaves the last cell
  always_comb begin
    busy_d   = busy_q;
    done_d   = 1'b0;
    count_d  = count_q;
    status_d = status_q;
    if (accept) begin
      busy_d = 1'b1;
    end
    if (tok_w[CAPACITY].vld) begin
      busy_d   = 1'b0;
      done_d   = 1'b1;
      status_d = ST_MISS;
      unique case (op_q)
        OP_APPEND: begin
          if (count_q >= CAP_C) begin
            status_d = ST_FULL;
          end else begin
            status_d = ST_DONE;
            count_d  = count_q + CNT_W'(1);
          end
        end
        OP_DELETE: begin
          if (tok_w[CAPACITY].found) begin
            status_d = ST_DONE;
            count_d  = count_q - CNT_W'(1);
          end
        end
        OP_SEARCH: begin
          if (tok_w[CAPACITY].found) begin
            status_d = ST_DONE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      done_q   <= 1'b0;
      tok_q    <= '0;
      count_q  <= '0;
      status_q <= ST_MISS;
    end else begin
      busy_q    <= busy_d;
      done_q    <= done_d;
      tok_q.vld <= accept;
      tok_q.found <= 1'b0;
      count_q   <= count_d;
      status_q  <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= ovl_op_e'(operation_i);
      value_q <= value_i;
    end
  end

  assign count_ext = EXT_W'(count_q);
  assign busy_o    = busy_q;
  assign done_o    = done_q;
  assign status_o  = status_q;
  assign count_o   = count_ext[COUNT_W-1:0];

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result shown while busy");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o && !done_o))
    else $error("accepted item did not make the block busy");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CAP_C)
    else $error("entry count above capacity");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_q == ST_FULL) |-> (count_q == CAP_C))
    else $error("full reported with room left");

endmodule
